// ----- sv/iirl_pkg.sv -----
package iirl_pkg;

    localparam int DEPTH_DEFAULT       = 16;
    localparam int ENTRY_WIDTH_DEFAULT = 32;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_READ   = 3'd2,
        OP_PUSH   = 3'd3,
        OP_POP    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic shift_up;
        logic shift_down;
    } cell_cmd_t;

endpackage

// ----- sv/iirl_cell.sv -----
module iirl_cell #(
    parameter int INDEX       = 0,
    parameter int POS_WIDTH   = 5,
    parameter int ENTRY_WIDTH = iirl_pkg::ENTRY_WIDTH_DEFAULT
) (
    input  logic                   clk,
    input  iirl_pkg::cell_cmd_t    cmd,
    input  logic [POS_WIDTH-1:0]   target,
    input  logic [ENTRY_WIDTH-1:0] entry_in,
    input  logic [ENTRY_WIDTH-1:0] left_entry,
    input  logic [ENTRY_WIDTH-1:0] right_entry,
    output logic [ENTRY_WIDTH-1:0] entry,
    output logic [ENTRY_WIDTH-1:0] tap
);

    localparam logic [POS_WIDTH-1:0] MY_INDEX = POS_WIDTH'(INDEX);

    logic [ENTRY_WIDTH-1:0] entry_reg;
    logic [ENTRY_WIDTH-1:0] entry_next;
    logic                   at_target;
    logic                   above_target;

    assign at_target    = (target == MY_INDEX);
    assign above_target = (MY_INDEX > target);

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.shift_up)
        begin
            if (at_target)
            begin
                entry_next = entry_in;
            end
            else if (above_target)
            begin
                entry_next = left_entry;
            end
        end
        else if (cmd.shift_down)
        begin
            if (at_target || above_target)
            begin
                entry_next = right_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign tap   = at_target ? entry_reg : '0;

endmodule

// ----- sv/iirl_ctrl.sv -----
module iirl_ctrl #(
    parameter int DEPTH     = iirl_pkg::DEPTH_DEFAULT,
    parameter int POS_WIDTH = 5
) (
    input  logic                  accept,
    input  logic [2:0]            operation,
    input  logic [POS_WIDTH-1:0]  position,
    input  logic [POS_WIDTH-1:0]  count,
    output iirl_pkg::cell_cmd_t   cmd,
    output logic [POS_WIDTH-1:0]  target,
    output logic [POS_WIDTH-1:0]  count_next,
    output iirl_pkg::status_t     status,
    output logic                  gives_entry
);

    localparam logic [POS_WIDTH-1:0] FULL_COUNT = POS_WIDTH'(DEPTH);

    logic up;
    logic down;

    always_comb
    begin
        up          = 1'b0;
        down        = 1'b0;
        target      = position;
        status      = iirl_pkg::ST_MISS;
        gives_entry = 1'b0;
        case (operation)
            iirl_pkg::OP_INSERT:
            begin
                if (position > count)
                begin
                    status = iirl_pkg::ST_MISS;
                end
                else if (count == FULL_COUNT)
                begin
                    status = iirl_pkg::ST_FULL;
                end
                else
                begin
                    status = iirl_pkg::ST_OK;
                    up     = 1'b1;
                end
            end
            iirl_pkg::OP_PUSH:
            begin
                target = count;
                if (count == FULL_COUNT)
                begin
                    status = iirl_pkg::ST_FULL;
                end
                else
                begin
                    status = iirl_pkg::ST_OK;
                    up     = 1'b1;
                end
            end
            iirl_pkg::OP_REMOVE:
            begin
                if (position < count)
                begin
                    status      = iirl_pkg::ST_OK;
                    down        = 1'b1;
                    gives_entry = 1'b1;
                end
            end
            iirl_pkg::OP_READ:
            begin
                if (position < count)
                begin
                    status      = iirl_pkg::ST_OK;
                    gives_entry = 1'b1;
                end
            end
            iirl_pkg::OP_POP:
            begin
                target = count - POS_WIDTH'(1);
                if (count != '0)
                begin
                    status      = iirl_pkg::ST_OK;
                    down        = 1'b1;
                    gives_entry = 1'b1;
                end
            end
            default:
            begin
                status = iirl_pkg::ST_MISS;
            end
        endcase
    end

    assign cmd.shift_up   = accept && up;
    assign cmd.shift_down = accept && down;

    always_comb
    begin
        count_next = count;
        if (cmd.shift_up)
        begin
            count_next = count + POS_WIDTH'(1);
        end
        else if (cmd.shift_down)
        begin
            count_next = count - POS_WIDTH'(1);
        end
    end

endmodule

// ----- sv/indexed_insert_remove_list_top.sv -----
// Channel  | Ports                                              | Handshake
// ---------+----------------------------------------------------+--------------------------
// request  | operation, position, entry_in                      | start high, busy low
// result   | entry_out, status, entry_count, is_empty           | done high for one cycle
//
// Every cell of the row shifts, loads or holds in parallel at the accepting edge, and
// the result is shown with done in the next cycle. A new item may be accepted in every
// cycle while busy is low.
// After reset busy is high for one cycle, and the list is empty.
// The receiver cannot stall; done lasts exactly one cycle.
module indexed_insert_remove_list_top #(
    parameter int DEPTH       = iirl_pkg::DEPTH_DEFAULT,
    parameter int ENTRY_WIDTH = iirl_pkg::ENTRY_WIDTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   operation,
    input  logic [$clog2(DEPTH+1)-1:0]   position,
    input  logic [ENTRY_WIDTH-1:0]       entry_in,
    output logic                         done,
    output logic [ENTRY_WIDTH-1:0]       entry_out,
    output logic [1:0]                   status,
    output logic [$clog2(DEPTH+1)-1:0]   entry_count,
    output logic                         is_empty
);

    localparam int POS_WIDTH = $clog2(DEPTH + 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [ENTRY_WIDTH-1:0] entry_out_reg;
    logic [ENTRY_WIDTH-1:0] entry_out_next;
    iirl_pkg::status_t      status_reg;
    logic [POS_WIDTH-1:0]   count_reg;
    logic [POS_WIDTH-1:0]   count_next;

    logic                   accept;
    iirl_pkg::cell_cmd_t    cmd;
    logic [POS_WIDTH-1:0]   target;
    iirl_pkg::status_t      status_now;
    logic                   gives_entry;
    logic [ENTRY_WIDTH-1:0] read_data;

    logic [ENTRY_WIDTH-1:0] cell_entry [DEPTH];
    logic [ENTRY_WIDTH-1:0] cell_tap   [DEPTH];

    assign accept = start && !busy_reg;

    iirl_ctrl #(
        .DEPTH     (DEPTH),
        .POS_WIDTH (POS_WIDTH)
    ) u_ctrl (
        .accept      (accept),
        .operation   (operation),
        .position    (position),
        .count       (count_reg),
        .cmd         (cmd),
        .target      (target),
        .count_next  (count_next),
        .status      (status_now),
        .gives_entry (gives_entry)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        iirl_cell #(
            .INDEX       (i),
            .POS_WIDTH   (POS_WIDTH),
            .ENTRY_WIDTH (ENTRY_WIDTH)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .target      (target),
            .entry_in    (entry_in),
            .left_entry  (cell_entry[(i == 0) ? 0 : i - 1]),
            .right_entry (cell_entry[(i == DEPTH - 1) ? DEPTH - 1 : i + 1]),
            .entry       (cell_entry[i]),
            .tap         (cell_tap[i])
        );
    end

    always_comb
    begin
        read_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            read_data = read_data | cell_tap[i];
        end
    end

    assign entry_out_next = gives_entry ? read_data : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b1;
            done_reg   <= 1'b0;
            count_reg  <= '0;
            status_reg <= iirl_pkg::ST_OK;
        end
        else
        begin
            busy_reg  <= 1'b0;
            done_reg  <= accept;
            count_reg <= count_next;
            if (accept)
            begin
                status_reg <= status_now;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_out_reg <= entry_out_next;
        end
    end

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign entry_out   = entry_out_reg;
    assign status      = status_reg;
    assign entry_count = count_reg;
    assign is_empty    = (count_reg == '0);

    a_done_follows_accept : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done_reg)
        else $error("accepted item gave no result");

    a_count_steps_by_one : assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> count_reg == $past(count_reg))
        else $error("count moved without an accepted item");

    a_count_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= POS_WIDTH'(DEPTH))
        else $error("count exceeds depth");

    a_miss_leaves_state : assert property (@(posedge clk) disable iff (!rst_n)
        accept && status_now != iirl_pkg::ST_OK
        |=> entry_out_reg == '0 && count_reg == $past(count_reg))
        else $error("refused item changed state or returned an entry");

endmodule

// ----- test/iirl_checker.sv -----
`timescale 1ns / 1ps

module iirl_checker #(
    parameter int DEPTH       = 16,
    parameter int ENTRY_WIDTH = 32,
    parameter int CW          = $clog2(DEPTH + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic [2:0]             operation,
    input  logic [CW-1:0]          position,
    input  logic [ENTRY_WIDTH-1:0] entry_in,
    input  logic                   done,
    input  logic [ENTRY_WIDTH-1:0] entry_out,
    input  logic [1:0]             status,
    input  logic [CW-1:0]          entry_count,
    input  logic                   is_empty,
    output int                     errors,
    output int                     pending,
    output int                     checked,
    output int                     full_refusals,
    output int                     misses,
    output int                     peak_count
);

    typedef struct packed {
        logic [ENTRY_WIDTH-1:0] entry;
        iirl_pkg::status_t      st;
        logic [CW-1:0]          cnt;
        logic                   empty;
    } outcome_t;

    logic [ENTRY_WIDTH-1:0] list_mem [DEPTH];
    int                     held;
    outcome_t               outcome_q [$];

    initial
    begin
        errors        = 0;
        pending       = 0;
        checked       = 0;
        full_refusals = 0;
        misses        = 0;
        peak_count    = 0;
        held          = 0;
    end

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h",
                 $time, checked, field, got, want);
    endtask

    task automatic predict_list_op(input logic [2:0] op, input logic [CW-1:0] pos,
                                   input logic [ENTRY_WIDTH-1:0] val);
        outcome_t o;
        int       p;
        o     = '0;
        o.st  = iirl_pkg::ST_MISS;
        p     = int'(pos);
        case (op)
            iirl_pkg::OP_INSERT, iirl_pkg::OP_PUSH:
            begin
                if (op == iirl_pkg::OP_PUSH)
                    p = held;
                if (p > held)
                    o.st = iirl_pkg::ST_MISS;
                else if (held >= DEPTH)
                    o.st = iirl_pkg::ST_FULL;
                else
                begin
                    for (int i = held; i > p; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[p] = val;
                    held++;
                    o.st = iirl_pkg::ST_OK;
                end
            end
            iirl_pkg::OP_REMOVE, iirl_pkg::OP_POP:
            begin
                if (op == iirl_pkg::OP_POP)
                    p = held - 1;
                if (p >= 0 && p < held)
                begin
                    o.entry = list_mem[p];
                    for (int i = p; i + 1 < held; i++)
                        list_mem[i] = list_mem[i+1];
                    held--;
                    o.st = iirl_pkg::ST_OK;
                end
            end
            iirl_pkg::OP_READ:
            begin
                if (p < held)
                begin
                    o.entry = list_mem[p];
                    o.st    = iirl_pkg::ST_OK;
                end
            end
            default:
            begin
            end
        endcase
        o.cnt   = CW'(held);
        o.empty = (held == 0);
        if (o.st == iirl_pkg::ST_FULL)
            full_refusals++;
        if (o.st == iirl_pkg::ST_MISS)
            misses++;
        if (held > peak_count)
            peak_count = held;
        outcome_q.push_back(o);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            held = 0;
            outcome_q.delete();
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (outcome_q.size() == 0)
                begin
                    errors++;
                    $display("[%0t] result with no item waiting for it", $time);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (entry_out !== want.entry)
                        report_mismatch("entry_out", 64'(entry_out), 64'(want.entry));
                    if (status !== want.st)
                        report_mismatch("status", 64'(status), 64'(want.st));
                    if (entry_count !== want.cnt)
                        report_mismatch("entry_count", 64'(entry_count), 64'(want.cnt));
                    if (is_empty !== want.empty)
                        report_mismatch("is_empty", 64'(is_empty), 64'(want.empty));
                end
                checked++;
            end
            if (start && !busy)
                predict_list_op(operation, position, entry_in);
            pending <= outcome_q.size();
        end
    end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH = 16;
    localparam int EW    = 32;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int LIMIT = 200000;

    logic          clk         = 1'b0;
    logic          rst_n       = 1'b0;
    logic          start       = 1'b0;
    logic [2:0]    operation   = '0;
    logic [CW-1:0] position    = '0;
    logic [EW-1:0] entry_in    = '0;
    logic          busy;
    logic          done;
    logic [EW-1:0] entry_out;
    logic [1:0]    status;
    logic [CW-1:0] entry_count;
    logic          is_empty;

    int errors;
    int pending;
    int checked;
    int full_refusals;
    int misses;
    int peak_count;
    int cycles  = 0;
    int sent    = 0;
    bit idling  = 1'b1;

    always #5 clk = ~clk;

    indexed_insert_remove_list_top #(
        .DEPTH       (DEPTH),
        .ENTRY_WIDTH (EW)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .position    (position),
        .entry_in    (entry_in),
        .done        (done),
        .entry_out   (entry_out),
        .status      (status),
        .entry_count (entry_count),
        .is_empty    (is_empty)
    );

    iirl_checker #(
        .DEPTH       (DEPTH),
        .ENTRY_WIDTH (EW)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .position      (position),
        .entry_in      (entry_in),
        .done          (done),
        .entry_out     (entry_out),
        .status        (status),
        .entry_count   (entry_count),
        .is_empty      (is_empty),
        .errors        (errors),
        .pending       (pending),
        .checked       (checked),
        .full_refusals (full_refusals),
        .misses        (misses),
        .peak_count    (peak_count)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycles, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int draw_gap();
        return idling ? int'($urandom_range(0, 18)) : 0;
    endfunction

    task automatic send_item(input logic [2:0] op, input logic [CW-1:0] pos,
                             input logic [EW-1:0] val);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        position  <= pos;
        entry_in  <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int            phase;
        int            r;
        int            cnt;
        logic [2:0]    op;
        logic [CW-1:0] pos;
        logic [EW-1:0] val;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list: every request that needs an entry must miss.
        send_item(iirl_pkg::OP_POP, '0, '0);
        send_item(iirl_pkg::OP_REMOVE, '0, '0);
        send_item(iirl_pkg::OP_READ, '0, '0);
        send_item(iirl_pkg::OP_INSERT, CW'(1), 32'h1234_5678);
        for (int k = 5; k <= 7; k++)
            send_item(3'(k), '0, 32'hDEAD_BEEF);
        send_item(iirl_pkg::OP_INSERT, '0, '0);
        send_item(iirl_pkg::OP_INSERT, '0, '1);
        send_item(iirl_pkg::OP_INSERT, CW'(2), 32'hA5A5_A5A5);
        send_item(iirl_pkg::OP_INSERT, CW'(1), 32'h5A5A_5A5A);
        for (int k = 4; k < DEPTH; k++)
            send_item(iirl_pkg::OP_PUSH, '0, $urandom);
        // Full list: the index check comes before the full check.
        send_item(iirl_pkg::OP_PUSH, '0, 32'hFFFF_0000);
        send_item(iirl_pkg::OP_INSERT, '0, 32'h0000_FFFF);
        send_item(iirl_pkg::OP_INSERT, CW'(DEPTH + 1), 32'h0F0F_0F0F);
        send_item(iirl_pkg::OP_READ, CW'(DEPTH - 1), '0);
        send_item(iirl_pkg::OP_REMOVE, '0, '0);
        send_item(iirl_pkg::OP_POP, '1, '1);
        drain_results();

        phase = 2;
        for (int i = 0; i < 400; i++)
        begin
            if (i % 50 == 0)
            begin
                phase  = $urandom_range(0, 2);
                idling = ($urandom_range(0, 3) != 0);
            end
            if (i % 100 == 99)
                drain_results();
            r = $urandom_range(0, 99);
            if (r < 4)
                op = 3'($urandom_range(5, 7));
            else
            begin
                r = $urandom_range(0, 99);
                if (phase == 0)
                    op = (r < 35) ? iirl_pkg::OP_PUSH : (r < 70) ? iirl_pkg::OP_INSERT :
                         (r < 80) ? iirl_pkg::OP_READ : (r < 90) ? iirl_pkg::OP_REMOVE :
                         iirl_pkg::OP_POP;
                else if (phase == 1)
                    op = (r < 10) ? iirl_pkg::OP_PUSH : (r < 20) ? iirl_pkg::OP_INSERT :
                         (r < 35) ? iirl_pkg::OP_READ : (r < 70) ? iirl_pkg::OP_REMOVE :
                         iirl_pkg::OP_POP;
                else
                    op = (r < 20) ? iirl_pkg::OP_PUSH : (r < 40) ? iirl_pkg::OP_INSERT :
                         (r < 60) ? iirl_pkg::OP_READ : (r < 80) ? iirl_pkg::OP_REMOVE :
                         iirl_pkg::OP_POP;
            end
            cnt = int'(entry_count);
            if ($urandom_range(0, 9) == 0)
                pos = CW'($urandom_range(0, 31));
            else
                pos = CW'($urandom_range(0, cnt + 1));
            r = $urandom_range(0, 15);
            val = (r == 0) ? '0 : (r == 1) ? '1 : EW'($urandom);
            send_item(op, pos, val);
        end

        drain_results();
        repeat (4) @(posedge clk);
        $display("Sent %0d requests and checked %0d results: %0d misses, %0d refused as full.",
                 sent, checked, misses, full_refusals);
        $display("The list reached %0d of %0d entries.", peak_count, DEPTH);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- indexed_insert_remove_list_top.f -----
sv/iirl_pkg.sv
sv/iirl_cell.sv
sv/iirl_ctrl.sv
sv/indexed_insert_remove_list_top.sv
test/iirl_checker.sv
test/tb.sv
